FILE: design/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants for the 3-D vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int COMPONENT_BITS_DEF = 32;   // default component width
    localparam int FRACTION_BITS_DEF  = 30;   // default result fraction bits
    localparam int UNIT_BITS          = 32;   // width of each unit output field
    localparam int AXES               = 3;    // x, y, z

endpackage

FILE: design/vn_root_stage.sv
// ----------------------------------------------------------------------------
// vn_root_stage
// One result bit of c / sqrt(S) for all three axes, restoring style.
// ----------------------------------------------------------------------------
module vn_root_stage #(
    parameter int COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = vn_pkg::FRACTION_BITS_DEF,
    parameter int BIT            = 0
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic                                          i_zero,
    input  logic [2*COMPONENT_BITS+1:0]                   i_s,
    input  logic [2*COMPONENT_BITS+2*FRACTION_BITS+1:0]   i_r [vn_pkg::AXES],
    input  logic [2*COMPONENT_BITS+2*FRACTION_BITS+1:0]   i_t [vn_pkg::AXES],
    input  logic [FRACTION_BITS:0]                        i_q [vn_pkg::AXES],
    input  logic                                          i_neg [vn_pkg::AXES],
    output logic                                          o_valid,
    output logic                                          o_zero,
    output logic [2*COMPONENT_BITS+1:0]                   o_s,
    output logic [2*COMPONENT_BITS+2*FRACTION_BITS+1:0]   o_r [vn_pkg::AXES],
    output logic [2*COMPONENT_BITS+2*FRACTION_BITS+1:0]   o_t [vn_pkg::AXES],
    output logic [FRACTION_BITS:0]                        o_q [vn_pkg::AXES],
    output logic                                          o_neg [vn_pkg::AXES]
);
    import vn_pkg::*;

    localparam int W  = 2*COMPONENT_BITS + 2*FRACTION_BITS + 2;
    localparam int SW = 2*COMPONENT_BITS + 2;
    localparam int QW = FRACTION_BITS + 1;

    logic [W-1:0]  s_ext;
    logic [W-1:0]  d   [AXES];
    logic          take[AXES];
    logic [W-1:0]  n_r [AXES];
    logic [W-1:0]  n_t [AXES];
    logic [QW-1:0] n_q [AXES];

    logic          r_valid;
    logic          r_zero;
    logic [SW-1:0] r_s;
    logic [W-1:0]  r_r  [AXES];
    logic [W-1:0]  r_t  [AXES];
    logic [QW-1:0] r_q  [AXES];
    logic          r_neg[AXES];

    assign s_ext = {{(W-SW){1'b0}}, i_s};

    // trial: (q + 2^b)^2 S = q^2 S + (qS << (b+1)) + (S << 2b)
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            d[k]    = (i_t[k] << (BIT+1)) + (s_ext << (2*BIT));
            take[k] = (i_r[k] >= d[k]);
            n_r[k]  = take[k] ? (i_r[k] - d[k]) : i_r[k];
            n_t[k]  = take[k] ? (i_t[k] + (s_ext << BIT)) : i_t[k];
            n_q[k]  = take[k] ? (i_q[k] | (QW'(1) << BIT)) : i_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero <= i_zero;
            r_s    <= i_s;
            for (int k = 0; k < AXES; k++) begin
                r_r[k]   <= n_r[k];
                r_t[k]   <= n_t[k];
                r_q[k]   <= n_q[k];
                r_neg[k] <= i_neg[k];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_zero  = r_zero;
    assign o_s     = r_s;
    assign o_r     = r_r;
    assign o_t     = r_t;
    assign o_q     = r_q;
    assign o_neg   = r_neg;

endmodule

FILE: design/vector3_normalizer_core.sv
// ----------------------------------------------------------------------------
// Registers from input to result: stage A, stage B, the root chain, the output register.
// Throughput: one transaction per cycle unless stalled; one result bit per root stage.
// Stall: the whole pipeline freezes while the output register is held.
// Reset: synchronous active-low i_rst_n clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// vector3_normalizer_core
// Scales a 3-D vector to unit length, Q1.FRACTION_BITS, truncated toward zero.
// ----------------------------------------------------------------------------
module vector3_normalizer_core #(
    parameter int COMPONENT_BITS = vn_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = vn_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [COMPONENT_BITS-1:0] i_x_in,
    input  logic signed [COMPONENT_BITS-1:0] i_y_in,
    input  logic signed [COMPONENT_BITS-1:0] i_z_in,
    // output channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [vn_pkg::UNIT_BITS-1:0] o_x_unit,
    output logic signed [vn_pkg::UNIT_BITS-1:0] o_y_unit,
    output logic signed [vn_pkg::UNIT_BITS-1:0] o_z_unit,
    output logic                             o_zero_vector
);
    import vn_pkg::*;

    localparam int C  = COMPONENT_BITS;
    localparam int W  = 2*COMPONENT_BITS + 2*FRACTION_BITS + 2;  // remainder width
    localparam int SW = 2*COMPONENT_BITS + 2;                    // sum of squares
    localparam int QW = FRACTION_BITS + 1;                       // quotient bits
    localparam int NS = FRACTION_BITS + 1;                       // root stages

    // One enable for the whole pipe: advance unless the result is held.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ---- stage A: magnitudes, signs, squares --------------------------------
    logic [C-1:0]   comp [AXES];
    logic           r_a_valid;
    logic [2*C-1:0] r_sq  [AXES];
    logic           r_a_neg [AXES];

    assign comp[0] = i_x_in;
    assign comp[1] = i_y_in;
    assign comp[2] = i_z_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    // Two's-complement negate in C bits also maps the most negative value
    // onto 2^(C-1), which is its true magnitude as an unsigned number.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < AXES; k++) begin
                logic [C-1:0] mag;
                mag        = comp[k][C-1] ? (~comp[k] + C'(1)) : comp[k];
                r_sq[k]    <= mag * mag;
                r_a_neg[k] <= comp[k][C-1];
            end
        end
    end

    // ---- stage B: sum of squares, remainder seed -----------------------------
    logic [SW-1:0] sum_sq;
    logic          r_b_valid;
    logic          r_b_zero;
    logic [SW-1:0] r_b_s;
    logic [W-1:0]  r_b_r  [AXES];
    logic          r_b_neg[AXES];

    assign sum_sq = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    // remainder starts at c^2 * 2^(2F); q and q*S start at zero
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_s    <= sum_sq;
            r_b_zero <= (sum_sq == '0);
            for (int k = 0; k < AXES; k++) begin
                r_b_r[k]   <= {{(W-2*C){1'b0}}, r_sq[k]} << (2*FRACTION_BITS);
                r_b_neg[k] <= r_a_neg[k];
            end
        end
    end

    // ---- root/divide chain: one quotient bit per stage, MSB first -----------
    logic          ch_valid[NS+1];
    logic          ch_zero [NS+1];
    logic [SW-1:0] ch_s    [NS+1];
    logic [W-1:0]  ch_r    [NS+1][AXES];
    logic [W-1:0]  ch_t    [NS+1][AXES];
    logic [QW-1:0] ch_q    [NS+1][AXES];
    logic          ch_neg  [NS+1][AXES];

    assign ch_valid[0] = r_b_valid;
    assign ch_zero[0]  = r_b_zero;
    assign ch_s[0]     = r_b_s;
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            ch_r[0][k]   = r_b_r[k];
            ch_t[0][k]   = '0;
            ch_q[0][k]   = '0;
            ch_neg[0][k] = r_b_neg[k];
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_root
        vn_root_stage #(
            .COMPONENT_BITS (COMPONENT_BITS),
            .FRACTION_BITS  (FRACTION_BITS),
            .BIT            (FRACTION_BITS - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ch_valid[g]),
            .i_zero  (ch_zero[g]),
            .i_s     (ch_s[g]),
            .i_r     (ch_r[g]),
            .i_t     (ch_t[g]),
            .i_q     (ch_q[g]),
            .i_neg   (ch_neg[g]),
            .o_valid (ch_valid[g+1]),
            .o_zero  (ch_zero[g+1]),
            .o_s     (ch_s[g+1]),
            .o_r     (ch_r[g+1]),
            .o_t     (ch_t[g+1]),
            .o_q     (ch_q[g+1]),
            .o_neg   (ch_neg[g+1])
        );
    end

    // ---- output register: sign, wrap to field width, zero-vector case -------
    logic [UNIT_BITS-1:0] unit_val[AXES];
    logic                 r_o_valid;
    logic                 r_o_zero;
    logic [UNIT_BITS-1:0] r_o_unit[AXES];

    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            logic [UNIT_BITS+QW-1:0] qx;
            qx          = {{UNIT_BITS{1'b0}}, ch_q[NS][k]};
            unit_val[k] = ch_neg[NS][k] ? (~qx[UNIT_BITS-1:0] + UNIT_BITS'(1))
                                        : qx[UNIT_BITS-1:0];
            if (ch_zero[NS]) begin
                unit_val[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= ch_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_zero <= ch_zero[NS];
            for (int k = 0; k < AXES; k++) begin
                r_o_unit[k] <= unit_val[k];
            end
        end
    end

    assign o_valid       = r_o_valid;
    assign o_zero_vector = r_o_zero;
    assign o_x_unit      = r_o_unit[0];
    assign o_y_unit      = r_o_unit[1];
    assign o_z_unit      = r_o_unit[2];

endmodule

FILE: tb/tb_vector3_normalizer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_normalizer_core
// Drives 3-D vectors into the normalizer with random gaps and output stalls,
// predicts each unit vector exactly and checks every result in order.
// ----------------------------------------------------------------------------
module tb_vector3_normalizer_core;

    import vn_pkg::*;

    localparam int CB        = COMPONENT_BITS_DEF;
    localparam int FB        = FRACTION_BITS_DEF;
    localparam int LATENCY   = FB + 4;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1200;

    typedef struct packed {
        logic signed [UNIT_BITS-1:0] x;
        logic signed [UNIT_BITS-1:0] y;
        logic signed [UNIT_BITS-1:0] z;
        logic                        zero;
    } t_unit_vec;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic signed [CB-1:0]  x_in = '0, y_in = '0, z_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic signed [UNIT_BITS-1:0] x_unit, y_unit, z_unit;
    logic                  zero_vector;

    t_unit_vec expected_units[$];
    int        n_errors = 0;
    int        idle_cycles = 0;
    bit        stall_enable = 1'b1;

    vector3_normalizer_core i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_x_in        (x_in),
        .i_y_in        (y_in),
        .i_z_in        (z_in),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_x_unit      (x_unit),
        .o_y_unit      (y_unit),
        .o_z_unit      (z_unit),
        .o_zero_vector (zero_vector)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Truncated c/sqrt(S): largest q with q*q*S <= c*c*2^(2*FB), bit by bit.
    function automatic logic [UNIT_BITS-1:0] scaled_component(
        logic [CB-1:0] mag, bit neg, logic [255:0] sum_sq);
        logic [255:0] target;
        logic [255:0] prod;
        logic [63:0]  q;
        logic [63:0]  cand;
        q = '0;
        target = (256'(mag) * 256'(mag)) << (2 * FB);
        for (int b = FB; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            prod = 256'(cand) * 256'(cand) * sum_sq;
            if (prod <= target) q = cand;
        end
        if (neg) q = ~q + 64'd1;
        return q[UNIT_BITS-1:0];
    endfunction

    function automatic t_unit_vec normalize(logic signed [CB-1:0] vx,
        logic signed [CB-1:0] vy, logic signed [CB-1:0] vz);
        logic [CB-1:0] mag[3];
        bit            neg[3];
        logic [CB-1:0] raw[3];
        logic [255:0]  sum_sq;
        t_unit_vec     r;
        raw[0] = vx; raw[1] = vy; raw[2] = vz;
        sum_sq = '0;
        for (int i = 0; i < AXES; i++) begin
            neg[i] = raw[i][CB-1];
            // two's complement of the most negative value is itself, read unsigned
            mag[i] = neg[i] ? (~raw[i] + 1'b1) : raw[i];
            sum_sq += 256'(mag[i]) * 256'(mag[i]);
        end
        if (sum_sq == 0) begin
            r = '{x: '0, y: '0, z: '0, zero: 1'b1};
        end else begin
            r.x = scaled_component(mag[0], neg[0], sum_sq);
            r.y = scaled_component(mag[1], neg[1], sum_sq);
            r.z = scaled_component(mag[2], neg[2], sum_sq);
            r.zero = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Random gap: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // One transaction on the input channel; entered and left at a falling edge.
    // Valid stays high between back-to-back transactions.
    task automatic send_vector(logic signed [CB-1:0] vx, logic signed [CB-1:0] vy,
        logic signed [CB-1:0] vz);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        x_in <= vx;
        y_in <= vy;
        z_in <= vz;
        do @(posedge clk); while (!in_ready);
        expected_units.push_back(normalize(vx, vy, vz));
        @(negedge clk);
    endtask

    // Output stall pattern, updated on every falling edge.
    initial begin
        int hold;
        forever begin
            @(negedge clk);
            if (!stall_enable) begin
                out_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else begin
                hold = gap_len();
                out_ready <= (hold == 0) ? 1'b1 : 1'b0;
            end
        end
    end

    // Result checker.
    initial begin
        t_unit_vec want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                if (expected_units.size() == 0) begin
                    report_mismatch("unexpected result", {x_unit, y_unit}, 64'd0);
                end else begin
                    want = expected_units.pop_front();
                    if (x_unit !== want.x) report_mismatch("x_unit", x_unit, want.x);
                    if (y_unit !== want.y) report_mismatch("y_unit", y_unit, want.y);
                    if (z_unit !== want.z) report_mismatch("z_unit", z_unit, want.z);
                    if (zero_vector !== want.zero)
                        report_mismatch("zero_vector", zero_vector, want.zero);
                end
            end
        end
    end

    // Watchdog: cycles with no transaction on either channel.
    initial begin
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("tb_vector3_normalizer_core NOT OK");
                $finish;
            end
        end
    end

    function automatic logic signed [CB-1:0] rand_component();
        logic signed [CB-1:0] v;
        int kind;
        kind = $urandom_range(0, 9);
        v = $urandom;
        case (kind)
            0: v = '0;
            1: v = {1'b1, {(CB-1){1'b0}}};
            2: v = {1'b0, {(CB-1){1'b1}}};
            3: v = $signed(CB'($urandom_range(0, 15))) - 8;
            4: v = v >>> $urandom_range(0, CB-2);
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_zero_vector();
        send_vector('0, '0, '0);
    endtask

    task automatic test_single_axis();
        logic signed [CB-1:0] mn, mx;
        mn = {1'b1, {(CB-1){1'b0}}};
        mx = {1'b0, {(CB-1){1'b1}}};
        send_vector(1, 0, 0);
        send_vector(0, -1, 0);
        send_vector(0, 0, mx);
        send_vector(mn, 0, 0);
        send_vector(0, mn, 0);
        send_vector(0, 0, -5);
    endtask

    task automatic test_extremes();
        logic signed [CB-1:0] mn, mx;
        mn = {1'b1, {(CB-1){1'b0}}};
        mx = {1'b0, {(CB-1){1'b1}}};
        send_vector(mn, mn, mn);
        send_vector(mx, mx, mx);
        send_vector(mn, mx, mn);
        send_vector(1, 1, 1);
        send_vector(-1, 1, -1);
        send_vector(3, 4, 0);
        send_vector(mx, 1, -1);
        send_vector(1, mn, 0);
        send_vector(2, 3, 6);
    endtask

    // Hold the sender until everything already issued has come back.
    task automatic test_drain_pause();
        send_vector(7, -11, 13);
        in_valid <= 1'b0;
        wait (expected_units.size() == 0);
        @(negedge clk);
        send_vector(-7, 11, -13);
    endtask

    task automatic test_random_vectors();
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) stall_enable = 1'b0;
            if (i == N_RANDOM / 2 + 100) stall_enable = 1'b1;
            send_vector(rand_component(), rand_component(), rand_component());
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_zero_vector();
        test_single_axis();
        test_extremes();
        test_drain_pause();
        test_random_vectors();
        in_valid <= 1'b0;
        wait (expected_units.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (n_errors == 0 && expected_units.size() == 0) begin
            $display("tb_vector3_normalizer_core OK");
        end else begin
            $display("tb_vector3_normalizer_core NOT OK");
        end
        $finish;
    end

endmodule
